// ===== src/rpr_pkg.sv =====
package rpr_pkg;

    // sizes
    localparam int MAX_TAPS    = 1024;
    localparam int MAX_PHASES  = 16;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int M_LIMIT     = 256;
    localparam int TAP_AW      = $clog2(MAX_TAPS);
    localparam int ACC_W       = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    // item kinds
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_COEF   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_UP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS = 2'd2;

    typedef struct packed {
        logic [1:0]                    action;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [9:0]                    coef_index;
        logic signed [COEF_BITS-1:0]   coef_value;
        logic                          fill_ones;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pcm_sample;
        logic                          saturated;
    } out_item_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIVR  = 7'b0000010,
        ST_FETCH = 7'b0000100,
        ST_LOADM = 7'b0001000,
        ST_MAC   = 7'b0010000,
        ST_SCALE = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

endpackage

// ===== src/rpr_ram.sv =====
module rpr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/polyphase_rational_resampler.sv =====
// channel   signals                          transaction when
// input     in_valid, in_stall, in_item      in_valid && !in_stall
// output    out_valid, out_stall, out_item   out_valid && !out_stall
// config    cfg_valid, cfg_ready, cfg_index  cfg_valid && cfg_ready (ready always high)
//
// load, clear and non-emitting sample items leave the block idle, ready for the next item.
// an emitting sample item passes through these steps in order:
// accept, remainder steps, the taps of the phase, closing fetch, gain steps, emit.
// each tap is a ram read (fetch, load) followed by a bit-serial multiply.
// no clearing pass: history holds a fill count, unwritten slots read as the fill value.
// a stalled output holds an emitting block in its last state, the next item waits.
module polyphase_rational_resampler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  rpr_pkg::in_item_t                   in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output rpr_pkg::out_item_t                  out_item,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpr_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rpr_pkg::*;

    localparam logic signed [ACC_W-1:0] SMAX = ACC_W'(2**(SAMPLE_BITS-1) - 1);
    localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2**(COEF_BITS-2));
    localparam logic [SAMPLE_BITS-1:0]  FILL_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    state_t                  state_reg, state_next;
    logic [4:0]              up_reg;
    logic [8:0]              down_reg;
    logic [10:0]             taps_reg;
    logic [8:0]              pc_reg, pc_next;
    logic [TAP_AW-1:0]       head_reg, head_next;
    logic [TAP_AW:0]         wcount_reg, wcount_next;
    logic [SAMPLE_BITS-1:0]  fill_reg, fill_next;
    logic [9:0]              num_reg, num_next;
    logic [3:0]              rem_reg, rem_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic [TAP_AW:0]         k_reg, k_next;
    logic [TAP_AW-1:0]       j_reg, j_next;
    logic                    hv_reg, hv_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [ACC_W-1:0]        mcand_reg, mcand_next;
    logic [COEF_BITS-1:0]    mult_reg, mult_next;
    logic                    out_valid_reg, out_valid_next;
    out_item_t               out_reg, out_next;

    logic [8:0]              m_eff;
    logic [4:0]              n0, n1, n_eff;
    logic [10:0]             t_eff;
    logic [8:0]              pc_sum;
    logic [4:0]              rtmp;
    logic                    accept;
    logic                    coef_we, hist_we;
    logic [TAP_AW-1:0]       hist_raddr;
    logic [COEF_BITS-1:0]    coef_rdata;
    logic [SAMPLE_BITS-1:0]  hist_rdata, hist_val;
    logic signed [ACC_W-1:0] rnd, q;

    // configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= 5'd1;
            down_reg <= 9'd1;
            taps_reg <= 11'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_UP:   up_reg   <= cfg_data[4:0];
                CFG_DOWN: down_reg <= cfg_data[8:0];
                CFG_TAPS: taps_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // clamped factors
    always_comb
    begin
        m_eff = (down_reg == 9'd0) ? 9'd1 :
                (down_reg > 9'(M_LIMIT)) ? 9'(M_LIMIT) : down_reg;
        n0    = (up_reg == 5'd0) ? 5'd1 : up_reg;
        n1    = (n0 > 5'(MAX_PHASES)) ? 5'(MAX_PHASES) : n0;
        n_eff = ({4'd0, n1} > m_eff) ? m_eff[4:0] : n1;
        t_eff = (taps_reg == 11'd0) ? 11'd1 :
                (taps_reg > 11'(MAX_TAPS)) ? 11'(MAX_TAPS) : taps_reg;
    end

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign in_stall   = (state_reg != ST_IDLE);
    assign pc_sum     = pc_reg + {4'd0, n_eff};
    assign coef_we    = accept && (in_item.action == ACT_COEF);
    assign hist_we    = accept && (in_item.action == ACT_SAMPLE);
    assign hist_raddr = head_reg + j_reg;
    assign hist_val   = hv_reg ? hist_rdata : fill_reg;
    assign rtmp       = {rem_reg, num_reg[9]};
    assign rnd        = $signed(acc_reg) + HALF;
    assign q          = rnd >>> (COEF_BITS - 1);

    rpr_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TAPS)) u_coef_ram (
        .clk     (clk),
        .wr_en   (coef_we),
        .wr_addr (in_item.coef_index),
        .wr_data (in_item.coef_value),
        .rd_addr (k_reg[TAP_AW-1:0]),
        .rd_data (coef_rdata)
    );

    rpr_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (head_reg - TAP_AW'(1)),
        .wr_data (in_item.sample_in),
        .rd_addr (hist_raddr),
        .rd_data (hist_rdata)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        head_next      = head_reg;
        wcount_next    = wcount_reg;
        fill_next      = fill_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        hv_next        = hv_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mult_next      = mult_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        // output register drains on a transaction
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_item.action)
                        ACT_SAMPLE:
                        begin
                            head_next   = head_reg - TAP_AW'(1);
                            wcount_next = (wcount_reg == (TAP_AW+1)'(MAX_TAPS)) ?
                                          wcount_reg : wcount_reg + (TAP_AW+1)'(1);
                            if (pc_sum < m_eff)
                            begin
                                pc_next = pc_sum;
                            end
                            else
                            begin
                                pc_next    = pc_sum - m_eff;
                                num_next   = {1'b0, pc_sum} - {1'b0, m_eff}
                                             + {5'd0, n_eff} - 10'd1;
                                rem_next   = 4'd0;
                                cnt_next   = 5'd0;
                                state_next = ST_DIVR;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            wcount_next = '0;
                            fill_next   = in_item.fill_ones ? FILL_MAX : '0;
                            pc_next     = 9'd0;
                        end
                        default: ;
                    endcase
                end
            end

            // restoring remainder, one numerator bit per cycle
            ST_DIVR:
            begin
                rem_next = (rtmp >= n_eff) ? 4'(rtmp - n_eff) : rtmp[3:0];
                num_next = {num_reg[8:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd9)
                begin
                    k_next     = {7'd0, rem_next};
                    j_next     = '0;
                    acc_next   = '0;
                    state_next = ST_FETCH;
                end
            end

            // address the rams for this tap, or finish
            ST_FETCH:
            begin
                if (k_reg >= t_eff)
                begin
                    mcand_next = acc_reg;
                    acc_next   = '0;
                    mult_next  = {{(COEF_BITS-5){1'b0}}, n_eff};
                    cnt_next   = 5'd0;
                    state_next = ST_SCALE;
                end
                else
                begin
                    hv_next    = {1'b0, j_reg} < wcount_reg;
                    state_next = ST_LOADM;
                end
            end

            ST_LOADM:
            begin
                mcand_next = {{(ACC_W-SAMPLE_BITS){hist_val[SAMPLE_BITS-1]}}, hist_val};
                mult_next  = coef_rdata;
                cnt_next   = 5'd0;
                state_next = ST_MAC;
            end

            // bit-serial multiply-accumulate, sign bit subtracts
            ST_MAC:
            begin
                if (mult_reg[0])
                begin
                    acc_next = (cnt_reg == 5'(COEF_BITS-1)) ? acc_reg - mcand_reg
                                                             : acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[ACC_W-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[COEF_BITS-1:1]};
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == 5'(COEF_BITS-1))
                begin
                    k_next     = k_reg + {6'd0, n_eff};
                    j_next     = j_reg + TAP_AW'(1);
                    state_next = ST_FETCH;
                end
            end

            // gain of n, shift-add over its five bits
            ST_SCALE:
            begin
                if (mult_reg[0])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[ACC_W-2:0], 1'b0};
                mult_next  = {1'b0, mult_reg[COEF_BITS-1:1]};
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == 5'd4)
                begin
                    state_next = ST_EMIT;
                end
            end

            // round, clip and hand to the output register
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    if (q > SMAX)
                    begin
                        out_next.pcm_sample = SMAX[SAMPLE_BITS-1:0];
                        out_next.saturated  = 1'b1;
                    end
                    else if (q < SMIN)
                    begin
                        out_next.pcm_sample = SMIN[SAMPLE_BITS-1:0];
                        out_next.saturated  = 1'b1;
                    end
                    else
                    begin
                        out_next.pcm_sample = q[SAMPLE_BITS-1:0];
                        out_next.saturated  = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            head_reg      <= '0;
            wcount_reg    <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            head_reg      <= head_next;
            wcount_reg    <= wcount_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        k_reg     <= k_next;
        j_reg     <= j_next;
        hv_reg    <= hv_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // checks
    a_nonsample_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (in_item.action != ACT_SAMPLE) |=> state_reg == ST_IDLE)
        else $error("non-sample item did not finish in one cycle");

    a_fetch_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) && (k_reg < t_eff) |=> state_reg == ST_LOADM)
        else $error("tap fetch did not load the multiplier");

    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        wcount_reg <= (TAP_AW+1)'(MAX_TAPS))
        else $error("history fill count out of range");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) && (state_next == ST_IDLE) |=> out_valid_reg)
        else $error("result left without raising output valid");

endmodule
